[sv/kce_pkg.sv]
// shared types, key codes and helpers for the keypad calculator entry block
package kce_pkg;

    localparam int unsigned DataW  = 32;
    localparam int unsigned KeyW   = 8;
    localparam int unsigned StepW  = $clog2(DataW);

    localparam logic [KeyW-1:0] KEY_PLUS  = 8'h2B;
    localparam logic [KeyW-1:0] KEY_MINUS = 8'h2D;
    localparam logic [KeyW-1:0] KEY_STAR  = 8'h2A;
    localparam logic [KeyW-1:0] KEY_SLASH = 8'h2F;
    localparam logic [KeyW-1:0] KEY_EQUAL = 8'h3D;
    localparam logic [KeyW-1:0] KEY_CLEAR = 8'h43;
    localparam logic [KeyW-1:0] KEY_ZERO  = 8'd48;
    localparam logic [KeyW-1:0] KEY_NINE  = 8'd57;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SIGN1,
        PH_NUM1,
        PH_OPER,
        PH_SIGN2,
        PH_NUM2
    } t_phase;

    typedef enum logic [2:0] {
        EV_IGNORE,
        EV_ECHO,
        EV_RESULT,
        EV_DIVZERO,
        EV_CLEAR,
        EV_BADKEY,
        EV_ABANDON
    } t_event;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } t_oper;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_PUSH
    } t_fsm;

    typedef struct packed {
        logic             start;
        logic             is_div;
        logic [DataW-1:0] a;
        logic [DataW-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic             done;
        logic [DataW-1:0] result;
    } t_alu_rsp;

    function automatic logic is_digit(input logic [KeyW-1:0] k);
        return (k >= KEY_ZERO) && (k <= KEY_NINE);
    endfunction

    // value * 10 + digit, wrapping
    function automatic logic [DataW-1:0] digit_step(input logic [DataW-1:0] v,
                                                     input logic [KeyW-1:0]  k);
        logic [KeyW-1:0] d;
        d = k - KEY_ZERO;
        return (v << 3) + (v << 1) + {{(DataW-KeyW){1'b0}}, d};
    endfunction

    function automatic logic [DataW-1:0] apply_sign(input logic [DataW-1:0] v,
                                                     input logic             neg);
        return neg ? (DataW'(0) - v) : v;
    endfunction

endpackage

[sv/keypad_calculator_entry.sv]
// keypad calculator entry: key decode, operand entry, sequencer and output register
//
// channel   dir  tdata                        tuser
// s_axis    in   key_code[7:0]                -
// m_axis    out  echo_char[7:0], answer[39:8] event_kind[2:0]
//
// a key with no arithmetic goes from the idle state to the push state, where
// its result register loads once the output register is free or being taken;
// '=' with multiply or nonzero divide first runs the 32 one-bit steps of the
// shared multiply/divide unit
// s_axis_tready is high only while the sequencer is idle; a result waits in
// its own output register, so a stalled m_axis lets one more key through and
// its finished result then holds off s_axis; synchronous active-low reset
// returns to idle entry
module keypad_calculator_entry
    import kce_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // key_code[7:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // echo_char[7:0], answer[39:8]
    output logic [2:0]  m_axis_tuser    // event_kind[2:0]
);

    t_fsm             r_fsm, n_fsm;
    t_phase           r_phase, n_phase;
    logic [DataW-1:0] r_fop, n_fop;
    logic [DataW-1:0] r_sop, n_sop;
    logic             r_fneg, n_fneg;
    logic             r_sneg, n_sneg;
    t_oper            r_oper, n_oper;

    t_event           r_ev, n_ev;
    logic [KeyW-1:0]  r_ch, n_ch;
    logic [DataW-1:0] r_ans, n_ans;
    logic             need_alu;

    logic             r_out_valid;
    t_event           r_out_ev;
    logic [KeyW-1:0]  r_out_ch;
    logic [DataW-1:0] r_out_ans;

    logic             in_xfer;
    logic             out_load;
    logic [KeyW-1:0]  key;
    logic [DataW-1:0] op_a, op_b;

    t_alu_req         alu_req;
    t_alu_rsp         alu_rsp;

    assign key     = s_axis_tdata;
    assign in_xfer = s_axis_tvalid && s_axis_tready;
    assign op_a    = apply_sign(r_fop, r_fneg);
    assign op_b    = apply_sign(r_sop, r_sneg);

    // key decode against the entry phase
    always_comb begin
        n_phase  = r_phase;
        n_fop    = r_fop;
        n_sop    = r_sop;
        n_fneg   = r_fneg;
        n_sneg   = r_sneg;
        n_oper   = r_oper;
        n_ev     = EV_IGNORE;
        n_ch     = '0;
        n_ans    = '0;
        need_alu = 1'b0;
        if (key == KEY_CLEAR) begin
            n_ev = EV_CLEAR;
            n_phase = PH_IDLE;
            n_fop = '0; n_sop = '0; n_fneg = 1'b0; n_sneg = 1'b0; n_oper = OP_ADD;
        end else begin
            case (r_phase)
                PH_SIGN1, PH_SIGN2: begin
                    if (is_digit(key)) begin
                        if (r_phase == PH_SIGN1) begin
                            n_fop   = digit_step('0, key);
                            n_phase = PH_NUM1;
                        end else begin
                            n_sop   = digit_step('0, key);
                            n_phase = PH_NUM2;
                        end
                        n_ev = EV_ECHO; n_ch = key;
                    end
                end
                PH_NUM1: begin
                    if (is_digit(key)) begin
                        n_fop = digit_step(r_fop, key);
                        n_ev = EV_ECHO; n_ch = key;
                    end else if (key == KEY_PLUS || key == KEY_MINUS ||
                                 key == KEY_STAR || key == KEY_SLASH) begin
                        if (key == KEY_PLUS) begin
                            n_oper = OP_ADD;
                        end else if (key == KEY_MINUS) begin
                            n_oper = OP_SUB;
                        end else if (key == KEY_STAR) begin
                            n_oper = OP_MUL;
                        end else begin
                            n_oper = OP_DIV;
                        end
                        n_phase = PH_OPER;
                        n_ev = EV_ECHO; n_ch = key;
                    end
                end
                PH_OPER: begin
                    if (is_digit(key)) begin
                        n_sop   = digit_step('0, key);
                        n_phase = PH_NUM2;
                        n_ev = EV_ECHO; n_ch = key;
                    end else if (key == KEY_PLUS || key == KEY_MINUS) begin
                        n_sneg  = (key == KEY_MINUS);
                        n_phase = PH_SIGN2;
                        n_ev = EV_ECHO; n_ch = key;
                    end else if (key == KEY_STAR || key == KEY_SLASH) begin
                        n_ev = EV_ABANDON;
                        n_phase = PH_IDLE;
                        n_fop = '0; n_sop = '0; n_fneg = 1'b0; n_sneg = 1'b0;
                        n_oper = OP_ADD;
                    end
                end
                PH_NUM2: begin
                    if (is_digit(key)) begin
                        n_sop = digit_step(r_sop, key);
                        n_ev = EV_ECHO; n_ch = key;
                    end else if (key == KEY_EQUAL) begin
                        n_ev = EV_RESULT;
                        case (r_oper)
                            OP_ADD:  n_ans = op_a + op_b;
                            OP_SUB:  n_ans = op_a - op_b;
                            OP_MUL:  need_alu = 1'b1;
                            default: begin
                                if (op_b == '0) begin
                                    n_ev = EV_DIVZERO;
                                end else begin
                                    need_alu = 1'b1;
                                end
                            end
                        endcase
                        n_phase = PH_IDLE;
                        n_fop = '0; n_sop = '0; n_fneg = 1'b0; n_sneg = 1'b0;
                        n_oper = OP_ADD;
                    end
                end
                default: begin
                    if (is_digit(key)) begin
                        n_fop   = digit_step('0, key);
                        n_phase = PH_NUM1;
                        n_ev = EV_ECHO; n_ch = key;
                    end else if (key == KEY_PLUS || key == KEY_MINUS) begin
                        n_fneg  = (key == KEY_MINUS);
                        n_phase = PH_SIGN1;
                        n_ev = EV_ECHO; n_ch = key;
                    end else begin
                        n_ev = EV_BADKEY; n_ch = key;
                        n_phase = PH_IDLE;
                        n_fop = '0; n_sop = '0; n_fneg = 1'b0; n_sneg = 1'b0;
                        n_oper = OP_ADD;
                    end
                end
            endcase
        end
    end

    // sequencer next state
    always_comb begin
        n_fsm = r_fsm;
        case (r_fsm)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_fsm = need_alu ? ST_RUN : ST_PUSH;
                end
            end
            ST_RUN: begin
                if (alu_rsp.done) begin
                    n_fsm = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_fsm = ST_IDLE;
                end
            end
            default: n_fsm = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
        case (r_fsm)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_RUN:  ;
            ST_PUSH: out_load = !r_out_valid || m_axis_tready;
            default: ;
        endcase
    end

    assign alu_req.start  = in_xfer && need_alu;
    assign alu_req.is_div = (r_oper == OP_DIV);
    assign alu_req.a      = op_a;
    assign alu_req.b      = op_b;

    kce_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .o_rsp   (alu_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= ST_IDLE;
            r_phase     <= PH_IDLE;
            r_fop       <= '0;
            r_sop       <= '0;
            r_fneg      <= 1'b0;
            r_sneg      <= 1'b0;
            r_oper      <= OP_ADD;
            r_out_valid <= 1'b0;
        end else begin
            r_fsm <= n_fsm;
            if (in_xfer) begin
                r_phase <= n_phase;
                r_fop   <= n_fop;
                r_sop   <= n_sop;
                r_fneg  <= n_fneg;
                r_sneg  <= n_sneg;
                r_oper  <= n_oper;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // pending result and output register payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_ev  <= n_ev;
            r_ch  <= n_ch;
            r_ans <= n_ans;
        end else if (r_fsm == ST_RUN && alu_rsp.done) begin
            r_ans <= alu_rsp.result;
        end
        if (out_load) begin
            r_out_ev  <= r_ev;
            r_out_ch  <= r_ch;
            r_out_ans <= r_ans;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_ans, r_out_ch};
    assign m_axis_tuser  = r_out_ev;

endmodule

[sv/kce_alu.sv]
// iterative multiply and signed divide unit, one bit per cycle over one shared adder
module kce_alu
    import kce_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    localparam logic [StepW-1:0] StepLast = StepW'(DataW - 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [StepW-1:0] r_cnt, n_cnt;
    logic             r_div, n_div;
    logic             r_neg, n_neg;
    logic [DataW-1:0] r_acc, n_acc;
    logic [DataW-1:0] r_x, n_x;
    logic [DataW-1:0] r_y, n_y;
    logic [DataW-1:0] r_rem, n_rem;

    logic [DataW-1:0] shifted;
    logic [DataW:0]   add_a, add_b, sum;

    // shared adder: accumulate for multiply, trial subtract for divide
    always_comb begin
        shifted = {r_rem[DataW-2:0], r_x[DataW-1]};
        if (r_div) begin
            add_a = {1'b0, shifted};
            add_b = {1'b0, ~r_y};
        end else begin
            add_a = {1'b0, r_acc};
            add_b = {1'b0, r_x};
        end
        sum = add_a + add_b + {{DataW{1'b0}}, r_div};
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_div  = r_div;
        n_neg  = r_neg;
        n_acc  = r_acc;
        n_x    = r_x;
        n_y    = r_y;
        n_rem  = r_rem;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_div  = i_req.is_div;
            n_acc  = '0;
            n_rem  = '0;
            if (i_req.is_div) begin
                n_neg = i_req.a[DataW-1] ^ i_req.b[DataW-1];
                n_x   = apply_sign(i_req.a, i_req.a[DataW-1]);
                n_y   = apply_sign(i_req.b, i_req.b[DataW-1]);
            end else begin
                n_neg = 1'b0;
                n_x   = i_req.a;
                n_y   = i_req.b;
            end
        end else if (r_busy) begin
            n_cnt = r_cnt + 1'b1;
            n_x   = r_x << 1;
            if (r_div) begin
                n_acc = {r_acc[DataW-2:0], sum[DataW]};
                n_rem = sum[DataW] ? sum[DataW-1:0] : shifted;
            end else begin
                n_y = r_y >> 1;
                if (r_y[0]) begin
                    n_acc = sum[DataW-1:0];
                end
            end
            if (r_cnt == StepLast) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_div <= n_div;
        r_neg <= n_neg;
        r_acc <= n_acc;
        r_x   <= n_x;
        r_y   <= n_y;
        r_rem <= n_rem;
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = (r_div && r_neg) ? (DataW'(0) - r_acc) : r_acc;

endmodule

[bench/keypad_calculator_entry_tb.sv]
// self-checking testbench for the keypad calculator entry block
module keypad_calculator_entry_tb;
    import kce_pkg::*;

    typedef struct packed {
        t_event      kind;
        logic [7:0]  ch;
        logic [31:0] value;
    } key_result_t;

    typedef struct packed {
        logic [7:0]  key;
        logic        typed;
        t_event      kind;
        logic [7:0]  ch;
        logic [31:0] value;
    } key_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // key_code[7:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;           // echo_char[7:0], answer[39:8]
    logic [2:0]  m_axis_tuser;           // event_kind[2:0]

    keypad_calculator_entry dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    t_phase      cur_phase = PH_IDLE;
    logic [31:0] lhs_mag = '0;
    logic [31:0] rhs_mag = '0;
    logic        lhs_neg = 1'b0;
    logic        rhs_neg = 1'b0;
    t_oper       op_sel = OP_ADD;

    key_result_t pending_events[$];
    logic [7:0]  key_seq[$];

    int error_count = 0;
    int keys_sent = 0;
    int random_acted = 0;
    int results_seen = 0;
    int n_answers = 0;
    int n_divzero = 0;
    int n_abandon = 0;
    int n_badkey = 0;
    int n_clear = 0;
    logic calm = 1'b0;
    logic rx_hold = 1'b0;

    // bad first key, clear, signs, minimum over minus one, stray operator, zero divisor with plus sign
    key_row_t entry_script [25] = '{
        '{8'hFF,     1'b1, EV_BADKEY,  8'hFF, 32'h0},
        '{KEY_CLEAR, 1'b1, EV_CLEAR,   8'h00, 32'h0},
        '{"-",       1'b0, EV_IGNORE,  8'h00, 32'h0},
        '{"2",       1'b0, EV_IGNORE,  8'h00, 32'h0},
        '{"1",       1'b0, EV_IGNORE,  8'h00, 32'h0},
        '{"4",       1'b0, EV_IGNORE,  8'h00, 32'h0},
        '{"7",       1'b0, EV_IGNORE,  8'h00, 32'h0},
        '{"4",       1'b0, EV_IGNORE,  8'h00, 32'h0},
        '{"8",       1'b0, EV_IGNORE,  8'h00, 32'h0},
        '{"3",       1'b0, EV_IGNORE,  8'h00, 32'h0},
        '{"6",       1'b0, EV_IGNORE,  8'h00, 32'h0},
        '{"4",       1'b0, EV_IGNORE,  8'h00, 32'h0},
        '{"8",       1'b0, EV_IGNORE,  8'h00, 32'h0},
        '{"/",       1'b0, EV_IGNORE,  8'h00, 32'h0},
        '{"-",       1'b0, EV_IGNORE,  8'h00, 32'h0},
        '{"1",       1'b0, EV_IGNORE,  8'h00, 32'h0},
        '{KEY_EQUAL, 1'b1, EV_RESULT,  8'h00, 32'h8000_0000},
        '{"3",       1'b0, EV_IGNORE,  8'h00, 32'h0},
        '{"*",       1'b0, EV_IGNORE,  8'h00, 32'h0},
        '{"/",       1'b1, EV_ABANDON, 8'h00, 32'h0},
        '{"5",       1'b0, EV_IGNORE,  8'h00, 32'h0},
        '{"/",       1'b0, EV_IGNORE,  8'h00, 32'h0},
        '{"+",       1'b0, EV_IGNORE,  8'h00, 32'h0},
        '{"0",       1'b0, EV_IGNORE,  8'h00, 32'h0},
        '{KEY_EQUAL, 1'b1, EV_DIVZERO, 8'h00, 32'h0}
    };

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= 40)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic void clear_calc();
        cur_phase = PH_IDLE;
        lhs_mag = '0;
        rhs_mag = '0;
        lhs_neg = 1'b0;
        rhs_neg = 1'b0;
        op_sel = OP_ADD;
    endfunction

    function automatic logic [31:0] shift_in_digit(input logic [31:0] v, input logic [7:0] k);
        logic [7:0] d;
        d = k - KEY_ZERO;
        return v * 32'd10 + {24'd0, d};
    endfunction

    function automatic key_result_t calc_event(input logic [7:0] k);
        key_result_t r;
        logic        is_dig;
        logic        is_op;
        logic [31:0] a, b, ma, mb, q;
        r.kind = EV_IGNORE;
        r.ch = '0;
        r.value = '0;
        is_dig = (k >= KEY_ZERO) && (k <= KEY_NINE);
        is_op = (k == KEY_PLUS) || (k == KEY_MINUS) || (k == KEY_STAR) || (k == KEY_SLASH);
        if (k == KEY_CLEAR) begin
            clear_calc();
            r.kind = EV_CLEAR;
        end else begin
            case (cur_phase)
                PH_SIGN1, PH_SIGN2: begin
                    if (is_dig) begin
                        if (cur_phase == PH_SIGN1) begin
                            lhs_mag = shift_in_digit('0, k);
                            cur_phase = PH_NUM1;
                        end else begin
                            rhs_mag = shift_in_digit('0, k);
                            cur_phase = PH_NUM2;
                        end
                        r.kind = EV_ECHO;
                        r.ch = k;
                    end
                end
                PH_NUM1: begin
                    if (is_dig) begin
                        lhs_mag = shift_in_digit(lhs_mag, k);
                        r.kind = EV_ECHO;
                        r.ch = k;
                    end else if (is_op) begin
                        case (k)
                            KEY_PLUS:  op_sel = OP_ADD;
                            KEY_MINUS: op_sel = OP_SUB;
                            KEY_STAR:  op_sel = OP_MUL;
                            default:   op_sel = OP_DIV;
                        endcase
                        cur_phase = PH_OPER;
                        r.kind = EV_ECHO;
                        r.ch = k;
                    end
                end
                PH_OPER: begin
                    if (is_dig) begin
                        rhs_mag = shift_in_digit('0, k);
                        cur_phase = PH_NUM2;
                        r.kind = EV_ECHO;
                        r.ch = k;
                    end else if (k == KEY_PLUS || k == KEY_MINUS) begin
                        rhs_neg = (k == KEY_MINUS);
                        cur_phase = PH_SIGN2;
                        r.kind = EV_ECHO;
                        r.ch = k;
                    end else if (is_op) begin
                        clear_calc();
                        r.kind = EV_ABANDON;
                    end
                end
                PH_NUM2: begin
                    if (is_dig) begin
                        rhs_mag = shift_in_digit(rhs_mag, k);
                        r.kind = EV_ECHO;
                        r.ch = k;
                    end else if (k == KEY_EQUAL) begin
                        a = lhs_neg ? (32'd0 - lhs_mag) : lhs_mag;
                        b = rhs_neg ? (32'd0 - rhs_mag) : rhs_mag;
                        r.kind = EV_RESULT;
                        case (op_sel)
                            OP_ADD: r.value = a + b;
                            OP_SUB: r.value = a - b;
                            OP_MUL: r.value = a * b;
                            default: begin
                                if (b == 32'd0) begin
                                    r.kind = EV_DIVZERO;
                                end else begin
                                    ma = a[31] ? (32'd0 - a) : a;
                                    mb = b[31] ? (32'd0 - b) : b;
                                    q = ma / mb;
                                    r.value = (a[31] ^ b[31]) ? (32'd0 - q) : q;
                                end
                            end
                        endcase
                        clear_calc();
                    end
                end
                default: begin
                    if (is_dig) begin
                        lhs_mag = shift_in_digit('0, k);
                        cur_phase = PH_NUM1;
                        r.kind = EV_ECHO;
                        r.ch = k;
                    end else if (k == KEY_PLUS || k == KEY_MINUS) begin
                        lhs_neg = (k == KEY_MINUS);
                        cur_phase = PH_SIGN1;
                        r.kind = EV_ECHO;
                        r.ch = k;
                    end else begin
                        clear_calc();
                        r.kind = EV_BADKEY;
                        r.ch = k;
                    end
                end
            endcase
        end
        return r;
    endfunction

    function automatic bit take_gap();
        return !calm && ($urandom_range(99) < 16);
    endfunction

    task automatic send_key(input logic [7:0] k, input logic typed, input key_result_t fixed);
        key_result_t r;
        if (take_gap()) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while (take_gap());
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= k;
        do @(posedge i_clk); while (!s_axis_tready);
        r = calc_event(k);
        pending_events.push_back(typed ? fixed : r);
        keys_sent++;
        if (r.kind != EV_IGNORE)
            random_acted++;
    endtask

    function automatic logic [7:0] any_key_but_clear();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (b == KEY_CLEAR);
        return b;
    endfunction

    task automatic queue_number();
        int n;
        n = ($urandom_range(9) == 0) ? $urandom_range(8, 11) : $urandom_range(1, 3);
        repeat (n) key_seq.push_back(KEY_ZERO + 8'($urandom_range(9)));
    endtask

    task automatic queue_sign();
        case ($urandom_range(2))
            1: key_seq.push_back(KEY_MINUS);
            2: key_seq.push_back(KEY_PLUS);
            default: ;
        endcase
    endtask

    // sign, number, operator, sign, number, equals; rare stray key before equals
    task automatic queue_entry();
        logic [7:0] op;
        queue_sign();
        queue_number();
        case ($urandom_range(3))
            0: op = KEY_PLUS;
            1: op = KEY_MINUS;
            2: op = KEY_STAR;
            default: op = KEY_SLASH;
        endcase
        key_seq.push_back(op);
        queue_sign();
        if (op == KEY_SLASH && $urandom_range(3) == 0)
            repeat ($urandom_range(1, 2)) key_seq.push_back(KEY_ZERO);
        else
            queue_number();
        if ($urandom_range(19) == 0)
            key_seq.push_back(any_key_but_clear());
        key_seq.push_back(KEY_EQUAL);
    endtask

    task automatic check_result();
        key_result_t want;
        results_seen++;
        if (pending_events.size() == 0) begin
            flag_error($sformatf("transfer with nothing pending, kind %0d", m_axis_tuser));
        end else begin
            want = pending_events.pop_front();
            if (m_axis_tuser !== want.kind)
                flag_error($sformatf("event kind %0d, want %0d", m_axis_tuser, want.kind));
            if (m_axis_tdata[7:0] !== want.ch)
                flag_error($sformatf("echo char %02h, want %02h", m_axis_tdata[7:0], want.ch));
            if (m_axis_tdata[39:8] !== want.value)
                flag_error($sformatf("answer %08h, want %08h", m_axis_tdata[39:8], want.value));
            case (want.kind)
                EV_RESULT:  n_answers++;
                EV_DIVZERO: n_divzero++;
                EV_ABANDON: n_abandon++;
                EV_BADKEY:  n_badkey++;
                EV_CLEAR:   n_clear++;
                default: ;
            endcase
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            check_result();
        m_axis_tready <= !rx_hold && (calm || $urandom_range(99) >= 16);
    end

    // long receiver stalls while keys keep coming
    initial begin
        while (keys_sent < 400) @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (300) @(posedge i_clk);
        rx_hold <= 1'b0;
        while (keys_sent < 1400) @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (300) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin
        #(12 * 1500000);
        $display("timeout: block stopped making progress");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        key_result_t fixed;
        int pick;
        int cut;
        int drain_cycles;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (entry_script[i]) begin
            fixed = {entry_script[i].kind, entry_script[i].ch, entry_script[i].value};
            send_key(entry_script[i].key, entry_script[i].typed, fixed);
        end

        random_acted = 0;
        while (random_acted < 1850) begin
            calm <= (random_acted >= 700) && (random_acted < 1000);
            key_seq.delete();
            pick = $urandom_range(99);
            if (pick < 70) begin
                queue_entry();
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 3)) key_seq.push_back(8'($urandom_range(255)));
            end else begin
                queue_entry();
                cut = $urandom_range(1, key_seq.size() - 1);
                while (key_seq.size() > cut) void'(key_seq.pop_back());
                case ($urandom_range(2))
                    0: key_seq.push_back(KEY_CLEAR);
                    1: key_seq.push_back($urandom_range(1) ? KEY_STAR : KEY_SLASH);
                    default: key_seq.push_back(8'($urandom_range(255)));
                endcase
            end
            while (key_seq.size() != 0)
                send_key(key_seq.pop_front(), 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;

        drain_cycles = 0;
        while (pending_events.size() != 0 && drain_cycles < 20000) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (40) @(posedge i_clk);
        if (pending_events.size() != 0)
            flag_error($sformatf("%0d results never arrived", pending_events.size()));

        $display("keys sent %0d, results checked %0d", keys_sent, results_seen);
        $display("answers %0d, divide by zero %0d, abandoned %0d, bad first keys %0d, clears %0d",
                 n_answers, n_divzero, n_abandon, n_badkey, n_clear);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
